[rtl/dtd_pkg.sv]
// Shared widths, display codes and register indexes for the differential
// thermometer display. No dependencies.
package dtd_pkg;

    localparam int CODE_W  = 10;   // converter code width
    localparam int VREF_W  = 3;    // reference volts register width
    localparam int MV_W    = 13;   // millivolt reading width
    localparam int SEG_W   = 8;    // segment code width
    localparam int CFG_IDX_W = 2;

    localparam int SAMPLES_LOG2_DEF = 4;

    localparam logic [SEG_W-1:0] SIGN_DEGREE = 8'd99;
    localparam logic [SEG_W-1:0] SIGN_MINUS  = 8'd64;
    localparam logic [SEG_W-1:0] POINT_BIT   = 8'h80;

    localparam logic [VREF_W-1:0] VREF_RESET  = 3'd5;
    localparam logic              POINT_RESET = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF_VOLTS = 2'd0,
        REG_DIGIT_POINT = 2'd1
    } cfg_reg_t;

    // one pair of block averages handed to the digit pipeline
    typedef struct packed {
        logic [MV_W-1:0] avg_out;
        logic [MV_W-1:0] avg_ref;
    } avg_beat_t;

    // seven-segment code of a decimal digit; blank above 9
    function automatic logic [SEG_W-1:0] seg_code(input logic [6:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            7'd0:    s = 8'h3F;
            7'd1:    s = 8'h06;
            7'd2:    s = 8'h5B;
            7'd3:    s = 8'h4F;
            7'd4:    s = 8'h66;
            7'd5:    s = 8'h6D;
            7'd6:    s = 8'h7D;
            7'd7:    s = 8'h07;
            7'd8:    s = 8'h7F;
            7'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

[rtl/dtd_digits.sv]
// Difference, magnitude and decimal digit split pipeline with segment coding.
// Depends on dtd_pkg.
module dtd_digits (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  dtd_pkg::avg_beat_t       in_beat,
    input  logic                     point,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [dtd_pkg::SEG_W-1:0] seg_hundreds,
    output logic [dtd_pkg::SEG_W-1:0] seg_tens,
    output logic [dtd_pkg::SEG_W-1:0] seg_units,
    output logic [dtd_pkg::SEG_W-1:0] seg_sign,
    output logic [dtd_pkg::MV_W-1:0]  magnitude_mv,
    output logic                     negative
);
    import dtd_pkg::*;

    // reciprocal constants: x/100 = (x*5243)>>19 for x < 2^13, r/10 = (r*205)>>11 for r < 100
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [7:0]  RECIP_10  = 8'd205;

    // stage valids
    logic v_mag_reg, v_q_reg, v_r_reg, v_t_reg, v_out_reg;
    logic rdy_out, rdy_t, rdy_r, rdy_q, rdy_mag;

    // stage payloads
    logic [MV_W-1:0] mag_reg, mag_q_reg, mag_r_reg, mag_t_reg;
    logic            neg_reg, neg_q_reg, neg_r_reg, neg_t_reg;
    logic [6:0]      q_reg, q_r_reg, q_t_reg;
    logic [6:0]      r_reg, r_t_reg;
    logic [3:0]      t_reg;

    logic [MV_W-1:0] mag_next;
    logic            neg_next;
    logic [25:0]     q_prod;
    logic [6:0]      q_next;
    logic [MV_W-1:0] r_wide;
    logic [6:0]      r_next;
    logic [14:0]     t_prod;
    logic [3:0]      t_next;
    logic [6:0]      u_wide;
    logic [3:0]      u_next;

    logic [SEG_W-1:0] seg_h_reg, seg_t_reg, seg_u_reg, seg_s_reg;
    logic [MV_W-1:0]  mag_out_reg;
    logic             neg_out_reg;

    assign rdy_out  = !v_out_reg || !out_stall;
    assign rdy_t    = !v_t_reg   || rdy_out;
    assign rdy_r    = !v_r_reg   || rdy_t;
    assign rdy_q    = !v_q_reg   || rdy_r;
    assign rdy_mag  = !v_mag_reg || rdy_q;
    assign in_ready = rdy_mag;

    // equal averages count as negative
    always_comb
    begin
        if (in_beat.avg_out > in_beat.avg_ref)
        begin
            mag_next = in_beat.avg_out - in_beat.avg_ref;
            neg_next = 1'b0;
        end
        else
        begin
            mag_next = in_beat.avg_ref - in_beat.avg_out;
            neg_next = 1'b1;
        end
    end

    assign q_prod = 26'(mag_reg) * 26'(RECIP_100);
    assign q_next = q_prod[25:19];
    assign r_wide = mag_q_reg - MV_W'(q_reg) * MV_W'(100);
    assign r_next = r_wide[6:0];
    assign t_prod = 15'(r_reg) * 15'(RECIP_10);
    assign t_next = t_prod[14:11];
    assign u_wide = r_t_reg - 7'(t_reg) * 7'd10;
    assign u_next = u_wide[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mag_reg <= 1'b0;
            v_q_reg   <= 1'b0;
            v_r_reg   <= 1'b0;
            v_t_reg   <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            if (rdy_mag) v_mag_reg <= in_valid;
            if (rdy_q)   v_q_reg   <= v_mag_reg;
            if (rdy_r)   v_r_reg   <= v_q_reg;
            if (rdy_t)   v_t_reg   <= v_r_reg;
            if (rdy_out) v_out_reg <= v_t_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_mag && in_valid)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (rdy_q && v_mag_reg)
        begin
            q_reg     <= q_next;
            mag_q_reg <= mag_reg;
            neg_q_reg <= neg_reg;
        end
        if (rdy_r && v_q_reg)
        begin
            r_reg     <= r_next;
            q_r_reg   <= q_reg;
            mag_r_reg <= mag_q_reg;
            neg_r_reg <= neg_q_reg;
        end
        if (rdy_t && v_r_reg)
        begin
            t_reg     <= t_next;
            r_t_reg   <= r_reg;
            q_t_reg   <= q_r_reg;
            mag_t_reg <= mag_r_reg;
            neg_t_reg <= neg_r_reg;
        end
        if (rdy_out && v_t_reg)
        begin
            seg_h_reg   <= seg_code(q_t_reg);
            seg_t_reg   <= seg_code(7'(t_reg)) | (point ? POINT_BIT : '0);
            seg_u_reg   <= seg_code(7'(u_next));
            seg_s_reg   <= neg_t_reg ? SIGN_MINUS : SIGN_DEGREE;
            mag_out_reg <= mag_t_reg;
            neg_out_reg <= neg_t_reg;
        end
    end

    assign out_valid    = v_out_reg;
    assign seg_hundreds = seg_h_reg;
    assign seg_tens     = seg_t_reg;
    assign seg_units    = seg_u_reg;
    assign seg_sign     = seg_s_reg;
    assign magnitude_mv = mag_out_reg;
    assign negative     = neg_out_reg;

endmodule

[rtl/differential_thermometer_display.sv]
// Top level of the differential thermometer display: input, scaling and
// block accumulation stages. Depends on dtd_pkg and dtd_digits.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per converter pair:
//   vout_code (sensor output) and ref_code (diode reference). A beat is taken
//   whenever in_valid is high and in_stall is low.
//   Each code is scaled to millivolts ((code*1000)>>10)*vref_volts and summed.
//   Every 2^SAMPLES_LOG2 beats the two sums are averaged and one result beat
//   leaves on out_valid / out_stall: segment codes for hundreds, tens, units,
//   the sign symbol, the magnitude in mV and the negative flag. Other input
//   beats produce no result.
//   Throughput: one input beat per cycle while in_stall is low.
//   Path: the completing beat passes the input, scale, average, difference,
//   /100, remainder, /10 and output registers in order before out_valid rises.
//   Stall: a stage holds its beat only when the next one is full and cannot
//   move, so input beats keep flowing while a result waits; in_stall rises
//   only once the whole pipe is backed up.
//   Reset: clears all valids, the sums and the pair count; vref_volts = 5,
//   second_digit_point = 1. Unknown config indexes are ignored; write when idle.
module differential_thermometer_display #(
    parameter int SAMPLES_LOG2 = dtd_pkg::SAMPLES_LOG2_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dtd_pkg::CODE_W-1:0]    vout_code,
    input  logic [dtd_pkg::CODE_W-1:0]    ref_code,
    input  logic                          cfg_wr_en,
    input  logic [dtd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtd_pkg::VREF_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dtd_pkg::SEG_W-1:0]     seg_hundreds,
    output logic [dtd_pkg::SEG_W-1:0]     seg_tens,
    output logic [dtd_pkg::SEG_W-1:0]     seg_units,
    output logic [dtd_pkg::SEG_W-1:0]     seg_sign,
    output logic [dtd_pkg::MV_W-1:0]      magnitude_mv,
    output logic                          negative
);
    import dtd_pkg::*;

    // scaled reading fits MV_W bits (7 * 999), so a block sum needs SAMPLES_LOG2 more
    localparam int SUM_W = MV_W + SAMPLES_LOG2;
    localparam int CNT_W = (SAMPLES_LOG2 > 0) ? SAMPLES_LOG2 : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'((2 ** SAMPLES_LOG2) - 1);

    // configuration registers
    logic [VREF_W-1:0] vref_reg;
    logic              point_reg;

    // input stage
    logic              v_in_reg;
    logic [CODE_W-1:0] vout_in_reg, ref_in_reg;
    logic [VREF_W-1:0] vref_in_reg;

    // scale stage: code*1000/1024
    logic              v_sc_reg;
    logic [CODE_W-1:0] vout_sc_reg, ref_sc_reg;
    logic [VREF_W-1:0] vref_sc_reg;
    logic [19:0]       vout_k, ref_k;

    // accumulator
    logic [SUM_W-1:0]  vout_sum_reg, ref_sum_reg;
    logic [SUM_W-1:0]  vout_sum_next, ref_sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic              last_pair;
    logic              acc_take;

    // averages handed to the digit pipeline
    logic              v_avg_reg;
    avg_beat_t         avg_reg;
    logic              dig_ready;

    logic rdy_avg, rdy_sc, rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_reg  <= VREF_RESET;
            point_reg <= POINT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_VREF_VOLTS:  vref_reg  <= cfg_data;
                REG_DIGIT_POINT: point_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ready chain: a stage loads when empty or when its beat moves on
    assign last_pair = (count_reg == LAST_CNT);
    assign rdy_avg   = !v_avg_reg || dig_ready;
    assign acc_take  = v_sc_reg && (!last_pair || rdy_avg);
    assign rdy_sc    = !v_sc_reg || acc_take;
    assign rdy_in    = !v_in_reg || rdy_sc;
    assign in_stall  = !rdy_in;

    assign vout_k = 20'(vout_in_reg) * 20'd1000;
    assign ref_k  = 20'(ref_in_reg) * 20'd1000;

    assign vout_sum_next = vout_sum_reg + SUM_W'(vout_sc_reg) * SUM_W'(vref_sc_reg);
    assign ref_sum_next  = ref_sum_reg  + SUM_W'(ref_sc_reg)  * SUM_W'(vref_sc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg     <= 1'b0;
            v_sc_reg     <= 1'b0;
            v_avg_reg    <= 1'b0;
            vout_sum_reg <= '0;
            ref_sum_reg  <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (rdy_in) v_in_reg <= in_valid;
            if (rdy_sc) v_sc_reg <= v_in_reg;
            if (acc_take)
            begin
                if (last_pair)
                begin
                    vout_sum_reg <= '0;
                    ref_sum_reg  <= '0;
                    count_reg    <= '0;
                end
                else
                begin
                    vout_sum_reg <= vout_sum_next;
                    ref_sum_reg  <= ref_sum_next;
                    count_reg    <= count_reg + 1'b1;
                end
            end
            if (rdy_avg) v_avg_reg <= acc_take && last_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in && in_valid)
        begin
            vout_in_reg <= vout_code;
            ref_in_reg  <= ref_code;
            vref_in_reg <= vref_reg;
        end
        if (rdy_sc && v_in_reg)
        begin
            vout_sc_reg <= vout_k[19:10];
            ref_sc_reg  <= ref_k[19:10];
            vref_sc_reg <= vref_in_reg;
        end
        if (acc_take && last_pair)
        begin
            avg_reg.avg_out <= vout_sum_next[SUM_W-1:SAMPLES_LOG2];
            avg_reg.avg_ref <= ref_sum_next[SUM_W-1:SAMPLES_LOG2];
        end
    end

    dtd_digits u_digits (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v_avg_reg),
        .in_ready     (dig_ready),
        .in_beat      (avg_reg),
        .point        (point_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .seg_hundreds (seg_hundreds),
        .seg_tens     (seg_tens),
        .seg_units    (seg_units),
        .seg_sign     (seg_sign),
        .magnitude_mv (magnitude_mv),
        .negative     (negative)
    );

    // sign symbol follows the negative flag
    a_sign_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (negative == (seg_sign == SIGN_MINUS)))
        else $error("sign symbol disagrees with negative flag");

    // a zero difference is always reported as negative
    a_zero_is_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !negative) |-> (magnitude_mv != '0))
        else $error("positive result with zero magnitude");

    // hundreds digit lit exactly below 1000 mV (a leading zero shows as 0)
    a_hundreds_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((seg_hundreds != '0) == (magnitude_mv < MV_W'(1000))))
        else $error("hundreds digit blanking wrong");

    // a completed block restarts the pair count
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_take && last_pair) |=> (count_reg == '0))
        else $error("pair count not restarted after block");

endmodule

[tb/differential_thermometer_display_tb.sv]
// Self-checking testbench for differential_thermometer_display: directed blocks of pairs,
// then randomized pairs under random input gaps and output stalls.
// Depends on dtd_pkg and the RTL top level only.
module differential_thermometer_display_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtd_pkg::*;

    // Block size and timing of the run
    localparam int SAMPLES_LOG2 = SAMPLES_LOG2_DEF;
    localparam int BLOCK        = 1 << SAMPLES_LOG2;
    localparam int HALF         = (BLOCK > 1) ? BLOCK / 2 : 1;
    localparam int LATENCY      = 7;        // completing beat to out_valid
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_PAIRS  = 56;       // 6 x 56 random pairs, 21 readings

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // One display reading, as it leaves the block
    typedef struct packed {
        logic [SEG_W-1:0] hundreds;
        logic [SEG_W-1:0] tens;
        logic [SEG_W-1:0] units;
        logic [SEG_W-1:0] sign;
        logic [MV_W-1:0]  mag;
        logic             neg;
    } reading_t;

    localparam reading_t NO_READING = '0;

    // Directed step: optional register setup, then a run of identical pairs.
    // When typed is set, the reading that the run completes is given here.
    typedef struct {
        bit       set_cfg;
        int       vref;
        int       point;
        bit       spare_wr;
        int       vout;
        int       refc;
        int       pairs;
        bit       typed;
        reading_t want;
    } dir_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CODE_W-1:0] vout_code = '0;
    logic [CODE_W-1:0] ref_code = '0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_VREF_VOLTS;
    logic [VREF_W-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_units;
    logic [SEG_W-1:0] seg_sign;
    logic [MV_W-1:0] magnitude_mv;
    logic negative;

    // Directed table. Equal readings count as negative; code 1 scales to 0 mV
    // and code 2 to 1 mV at 1 V; hundreds of 10 or more go blank.
    dir_step_t steps [15] = '{
        // zero in, zero out: minus sign, point on
        '{1'b1, 5, 1, 1'b0,    0,    0, BLOCK, 1'b1,
          '{8'h3F, 8'hBF, 8'h3F, SIGN_MINUS, 13'd0, 1'b0 | 1'b1}},
        // full scale above reference: 4995 mV, hundreds blank
        '{1'b0, 5, 1, 1'b0, 1023,    0, BLOCK, 1'b1,
          '{8'h00, 8'hEF, 8'h6D, SIGN_DEGREE, 13'd4995, 1'b0}},
        // full scale below reference
        '{1'b0, 5, 1, 1'b0,    0, 1023, BLOCK, 1'b1,
          '{8'h00, 8'hEF, 8'h6D, SIGN_MINUS, 13'd4995, 1'b1}},
        // equal codes
        '{1'b0, 5, 1, 1'b0,  512,  512, BLOCK, 1'b1,
          '{8'h3F, 8'hBF, 8'h3F, SIGN_MINUS, 13'd0, 1'b1}},
        // 1 V reference, point off: 999 mV
        '{1'b1, 1, 0, 1'b0, 1023,    0, BLOCK, 1'b1,
          '{8'h6F, 8'h6F, 8'h6F, SIGN_DEGREE, 13'd999, 1'b0}},
        '{1'b0, 1, 0, 1'b0,    1,    0, BLOCK, 1'b1,
          '{8'h3F, 8'h3F, 8'h3F, SIGN_MINUS, 13'd0, 1'b1}},
        '{1'b0, 1, 0, 1'b0,    2,    0, BLOCK, 1'b1,
          '{8'h3F, 8'h3F, 8'h06, SIGN_DEGREE, 13'd1, 1'b0}},
        // reference out of range high: 6993 mV
        '{1'b1, 7, 1, 1'b0, 1023,    0, BLOCK, 1'b1,
          '{8'h00, 8'hEF, 8'h4F, SIGN_DEGREE, 13'd6993, 1'b0}},
        // reference 0, point written as 3'b110 (bit 0 clear), spare writes
        '{1'b1, 0, 6, 1'b1, 1023,    0, BLOCK, 1'b1,
          '{8'h3F, 8'h3F, 8'h3F, SIGN_MINUS, 13'd0, 1'b1}},
        '{1'b1, 6, 1, 1'b0,  300,  700, BLOCK, 1'b0, NO_READING},
        '{1'b1, 3, 0, 1'b0,  850,  123, BLOCK, 1'b0, NO_READING},
        // register change in the middle of a block
        '{1'b1, 5, 1, 1'b0,  400,  100, HALF,  1'b0, NO_READING},
        '{1'b1, 2, 0, 1'b0,  400,  100, BLOCK - HALF, 1'b0, NO_READING},
        '{1'b1, 4, 1, 1'b0,  640,   37, BLOCK, 1'b0, NO_READING},
        '{1'b1, 5, 1, 1'b0,  123,  456, BLOCK, 1'b0, NO_READING}
    };

    // Mirror of the block's registers and accumulator
    logic [VREF_W-1:0] vref_setting;
    logic              point_setting;
    int unsigned       vout_total;
    int unsigned       ref_total;
    int                pairs_seen;

    reading_t pending_readings [$];
    int       mismatches = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    differential_thermometer_display #(
        .SAMPLES_LOG2(SAMPLES_LOG2)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .vout_code(vout_code),
        .ref_code(ref_code),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .seg_hundreds(seg_hundreds),
        .seg_tens(seg_tens),
        .seg_units(seg_units),
        .seg_sign(seg_sign),
        .magnitude_mv(magnitude_mv),
        .negative(negative)
    );

    always #6 clk = ~clk;

    // Run-away guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall, changed only on the falling edge
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic report_error(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d (0x%0h) want %0d (0x%0h)",
                                   name, got, got, want, want));
    endtask

    // Result monitor: every accepted result beat against the oldest reading
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
                report_error("result beat with no reading pending");
            else
            begin
                want = pending_readings.pop_front();
                check_field("seg_hundreds", seg_hundreds, want.hundreds);
                check_field("seg_tens", seg_tens, want.tens);
                check_field("seg_units", seg_units, want.units);
                check_field("seg_sign", seg_sign, want.sign);
                check_field("magnitude_mv", magnitude_mv, want.mag);
                check_field("negative", negative, want.neg);
            end
        end
    end

    function automatic logic [SEG_W-1:0] digit_seg(input int unsigned d);
        return (d < 10) ? DIGIT_SEGS[d] : '0;
    endfunction

    function automatic int unsigned code_to_mv(input logic [CODE_W-1:0] code);
        int unsigned c;
        c = code;
        return ((c * 1000) >> 10) * vref_setting;
    endfunction

    // Adds one pair to the running sums; done is set when a block completes
    task automatic accumulate_pair(input logic [CODE_W-1:0] v, input logic [CODE_W-1:0] r,
                                   output bit done, output reading_t rd);
        int unsigned avg_o;
        int unsigned avg_r;
        int unsigned diff;
        vout_total += code_to_mv(v);
        ref_total  += code_to_mv(r);
        pairs_seen++;
        done = 1'b0;
        rd   = NO_READING;
        if (pairs_seen == BLOCK)
        begin
            avg_o = vout_total >> SAMPLES_LOG2;
            avg_r = ref_total >> SAMPLES_LOG2;
            vout_total = 0;
            ref_total  = 0;
            pairs_seen = 0;
            rd.neg  = !(avg_o > avg_r);
            diff    = rd.neg ? avg_r - avg_o : avg_o - avg_r;
            rd.mag  = diff[MV_W-1:0];
            rd.sign = rd.neg ? SIGN_MINUS : SIGN_DEGREE;
            rd.hundreds = digit_seg(diff / 100);
            rd.tens  = digit_seg((diff % 100) / 10) | (point_setting ? POINT_BIT : '0);
            rd.units = digit_seg(diff % 10);
            done = 1'b1;
        end
    endtask

    // Sends one beat, starting and ending on a falling edge. A typed reading
    // replaces the predicted one for the beat that completes a block.
    task automatic send_pair(input logic [CODE_W-1:0] v, input logic [CODE_W-1:0] r,
                             input bit typed, input reading_t want);
        bit       done;
        reading_t rd;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        vout_code <= v;
        ref_code  <= r;
        do
            @(posedge clk);
        while (in_stall);
        accumulate_pair(v, r, done, rd);
        if (done)
            pending_readings.push_back(typed ? want : rd);
        @(negedge clk);
    endtask

    // Drain: every reading out, then let in-flight beats that complete no
    // block pass the pipe before touching a register.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // One write cycle, then cfg_wr_en drops again before the next write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VREF_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_VREF_VOLTS:  vref_setting = data;
            REG_DIGIT_POINT: point_setting = data[0];
            default: ;   // unmapped index, ignored by the block
        endcase
        @(negedge clk);
    endtask

    initial
    begin
        int               k;
        int               n;
        int               ph;
        logic [CODE_W-1:0] v;
        logic [CODE_W-1:0] r;

        vref_setting  = VREF_RESET;
        point_setting = POINT_RESET;
        vout_total = 0;
        ref_total  = 0;
        pairs_seen = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under light sender gaps and heavy receiver stalls
        send_idle_pct = 16;
        recv_idle_pct = 86;
        for (k = 0; k < $size(steps); k++)
        begin
            if (steps[k].set_cfg)
            begin
                wait_drained();
                write_reg(REG_VREF_VOLTS, VREF_W'(steps[k].vref));
                write_reg(REG_DIGIT_POINT, VREF_W'(steps[k].point));
                if (steps[k].spare_wr)
                begin
                    write_reg(REG_SPARE_LO, 3'd7);
                    write_reg(REG_SPARE_HI, 3'd6);
                end
            end
            for (n = 0; n < steps[k].pairs; n++)
                send_pair(CODE_W'(steps[k].vout), CODE_W'(steps[k].refc),
                          steps[k].typed, steps[k].want);
        end

        // Random part. Phases pair up by idling mode: sender light / receiver
        // heavy, then the reverse, then no idling at all. Each phase starts
        // from a drained pipe (partial block still summed) with new registers.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph / 2)
                0: begin send_idle_pct = 16; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            wait_drained();
            case (ph)
                0: write_reg(REG_VREF_VOLTS, 3'd5);
                1: write_reg(REG_VREF_VOLTS, 3'd1);
                2: write_reg(REG_VREF_VOLTS, 3'd7);
                3: write_reg(REG_VREF_VOLTS, 3'd0);
                default: write_reg(REG_VREF_VOLTS, VREF_W'($urandom_range(0, 7)));
            endcase
            // upper data bits random; only bit 0 lands in the point register
            write_reg(REG_DIGIT_POINT, {2'($urandom_range(0, 3)), ~ph[0]});
            if (ph == RAND_PHASES - 1)
                write_reg(REG_SPARE_HI, VREF_W'($urandom_range(0, 7)));

            for (n = 0; n < PHASE_PAIRS; n++)
            begin
                v = CODE_W'($urandom_range(0, 1023));
                r = CODE_W'($urandom_range(0, 1023));
                case ($urandom_range(0, 9))
                    0: begin
                        // rails
                        v = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                        r = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    end
                    1: r = v;                                   // tie
                    2: r = v ^ CODE_W'($urandom_range(0, 3));   // near tie
                    default: ;
                endcase
                send_pair(v, r, 1'b0, NO_READING);
            end
        end

        // Wind-down: all readings out, then watch for strays
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
